// ===== src/bpa_pkg.sv =====
// bitmap page allocator package: sizes, mode and status codes
// used by the allocator top level and its testbench
package bpa_pkg;
    localparam int NUM_PAGES_DEF  = 4096;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int WORD_BITS      = 64;
    localparam int ADDR_W         = 24;
    localparam int SIZE_W         = 25;
    localparam int MODE_W         = 3;
    localparam int ALOG_W         = 5;
    localparam int STAT_W         = 2;

    localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RETIRE  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DOUBLE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RETIRED = 2'd3;
endpackage

// ===== src/bpa_ram.sv =====
// generic single port synchronous ram with registered read
// no dependencies
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/bitmap_page_allocator.sv =====
// bitmap page allocator top level: sequencer over a word-wide bitmap ram
// depends on bpa_pkg and bpa_ram
//
// channel  | signals                                          | dir
// request  | i_start, o_busy, i_mode, i_byte_address,         | in
//          | i_byte_count, i_align_log2                       |
// result   | o_done, o_result_address, o_status,              | out
//          | o_range_low, o_range_high                        |
//
// after reset the bitmap ram is filled with ones, word by word, with busy high
// reserve, free, release: setup, read and modify per touched 64-page word (read if none), closing
// allocate scans from page zero, a read step and then one page per step for each 64-page word,
// then a setup step, a read and a modify step per marked word, and a closing step
// retire, retired and unknown modes: a setup and a closing step
// o_done is high in the same cycle that busy drops, with the result; the receiver cannot stall
module bitmap_page_allocator #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [bpa_pkg::MODE_W-1:0] i_mode,
    input  logic [bpa_pkg::ADDR_W-1:0] i_byte_address,
    input  logic [bpa_pkg::SIZE_W-1:0] i_byte_count,
    input  logic [bpa_pkg::ALOG_W-1:0] i_align_log2,
    output logic                       o_done,
    output logic [bpa_pkg::ADDR_W-1:0] o_result_address,
    output logic [bpa_pkg::STAT_W-1:0] o_status,
    output logic [bpa_pkg::ADDR_W-1:0] o_range_low,
    output logic [bpa_pkg::SIZE_W-1:0] o_range_high
);
    import bpa_pkg::*;

    localparam int NWORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PG_W   = $clog2(NUM_PAGES) + 1;
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int PW     = 34;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PREP, S_RD, S_MOD, S_SRD, S_SCAN, S_SETUP, S_DONE
    } t_state;

    t_state              r_state;
    logic [WA_W-1:0]     r_waddr;
    logic [PW-1:0]       r_first, r_last;
    logic                r_val;
    logic                r_dbl;
    logic [MODE_W-1:0]   r_mode;
    logic [ADDR_W-1:0]   r_addr;
    logic [SIZE_W-1:0]   r_size;
    logic [ALOG_W-1:0]   r_alog;
    logic [PW-1:0]       r_cand, r_incr, r_area, r_start;
    logic [PW-1:0]       r_tpage;
    logic [OFF_W-1:0]    r_toff;
    logic [ADDR_W-1:0]   r_lowest;
    logic [ADDR_W-1:0]   r_alow;
    logic [SIZE_W-1:0]   r_ahigh;
    logic                r_retired;
    logic [ADDR_W-1:0]   r_res;
    logic [STAT_W-1:0]   r_stat;
    logic                r_done;
    logic [BIT_W:0]      r_bit;

    logic                   we;
    logic [WA_W-1:0]        ram_addr;
    logic [WORD_BITS-1:0]   wdata, rdata;

    bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_map (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (ram_addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    // page-level helpers
    logic [PW-1:0] sz_pages, cur_page, cand_up, run_len;
    logic          page_bit;
    logic [PW-1:0] alignv;
    assign alignv   = PW'(1) << r_alog;
    assign sz_pages = (PW'(r_size) + PW'(PAGE_BYTES - 1)) >> OFF_W;
    assign cur_page = PW'({r_waddr, BIT_W'(0)}) | PW'(r_bit[BIT_W-1:0]);
    assign page_bit = rdata[r_bit[BIT_W-1:0]];
    assign cand_up  = cur_page + PW'(1);
    logic [PW-1:0] cand_rnd;
    assign cand_rnd = (cand_up & ~(r_incr - PW'(1))) + (((cand_up & (r_incr - PW'(1))) != 0)
                      ? r_incr : PW'(0));
    assign run_len  = cur_page - r_cand + PW'(1);

    // write mask for the current word over [r_first, r_last)
    logic [WORD_BITS-1:0] wmask;
    always_comb begin
        logic [PW-1:0] pg;
        for (int b = 0; b < WORD_BITS; b++) begin
            pg = PW'({r_waddr, BIT_W'(0)}) | PW'(b);
            wmask[b] = (pg >= r_first) && (pg < r_last) && (pg < PW'(NUM_PAGES));
        end
    end

    // allocation result helpers
    logic [PW-1:0] aoff, aroom, arest, aaddr, aend;
    logic [PW-1:0] abase, aend_raw;
    logic          atail;
    logic [PW-1:0] amask;
    assign amask = alignv - PW'(1);
    assign atail = (alignv < PW'(PAGE_BYTES)) && (r_toff != 0) && (r_tpage + PW'(1) == r_start);
    assign aoff  = (PW'(r_toff) + amask) & ~amask;
    assign aroom = PW'(PAGE_BYTES) - aoff;
    assign arest = PW'(r_size) - aroom;
    assign abase = atail ? ((r_tpage << OFF_W) + aoff) : (r_start << OFF_W);
    assign aaddr = abase & PW'(24'hFFFFFF);
    assign aend_raw = (aaddr + PW'(r_size) + amask) & ~amask;
    assign aend  = (aend_raw > PW'(25'h1FFFFFF)) ? PW'(25'h1FFFFFF) : aend_raw;

    always_comb begin
        we       = 1'b0;
        ram_addr = r_waddr;
        wdata    = rdata;
        if (r_state == S_CLEAR) begin
            we    = 1'b1;
            wdata = '1;
        end else if (r_state == S_MOD && r_val) begin
            we    = 1'b1;
            wdata = (r_mode == MODE_FREE || r_mode == MODE_RELEASE)
                    ? (rdata & ~wmask) : (rdata | wmask);
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_result_address = r_res;
    assign o_status         = r_stat;
    assign o_range_low      = r_alow;
    assign o_range_high     = r_ahigh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_waddr   <= '0;
            r_tpage   <= '0;
            r_toff    <= '0;
            r_lowest  <= '0;
            r_alow    <= '1;
            r_ahigh   <= '0;
            r_retired <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= (r_state == S_DONE);
            unique case (r_state)
                S_CLEAR: begin
                    r_waddr <= r_waddr + WA_W'(1);
                    if (r_waddr == WA_W'(NWORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_mode  <= i_mode;
                        r_addr  <= i_byte_address;
                        r_size  <= i_byte_count;
                        r_alog  <= i_align_log2;
                        r_dbl   <= 1'b0;
                        r_res   <= '0;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_val <= 1'b1;
                    if (r_retired) begin
                        r_stat  <= ST_RETIRED;
                        r_state <= S_DONE;
                    end else begin
                        unique case (r_mode)
                            MODE_RESERVE: begin
                                r_stat  <= ST_OK;
                                r_first <= PW'(r_addr) >> OFF_W;
                                r_last  <= (PW'(r_addr) + PW'(r_size) + PW'(PAGE_BYTES - 1))
                                           >> OFF_W;
                                r_waddr <= WA_W'((PW'(r_addr) >> OFF_W) >> BIT_W);
                                r_state <= S_RD;
                            end
                            MODE_FREE: begin
                                r_stat  <= ST_OK;
                                r_first <= PW'(r_addr) >> OFF_W;
                                r_last  <= (PW'(r_addr) >> OFF_W) + sz_pages;
                                r_waddr <= WA_W'((PW'(r_addr) >> OFF_W) >> BIT_W);
                                r_state <= S_RD;
                            end
                            MODE_RELEASE: begin
                                r_stat  <= ST_OK;
                                r_first <= (PW'(r_addr) + PW'(PAGE_BYTES - 1)) >> OFF_W;
                                r_last  <= (PW'(r_addr) + PW'(r_size)) >> OFF_W;
                                r_waddr <= WA_W'(((PW'(r_addr) + PW'(PAGE_BYTES - 1))
                                           >> OFF_W) >> BIT_W);
                                if (r_addr < r_lowest) begin
                                    r_lowest <= r_addr;
                                end
                                r_state <= S_RD;
                            end
                            MODE_ALLOC: begin
                                r_waddr <= '0;
                                r_area  <= sz_pages;
                                r_incr  <= ((alignv >> OFF_W) == PW'(0)) ? PW'(1)
                                           : (alignv >> OFF_W);
                                r_cand  <= '0;
                                r_bit   <= '0;
                                if (r_size == 0) begin
                                    r_stat  <= ST_NOFREE;
                                    r_state <= S_DONE;
                                end else begin
                                    r_stat  <= ST_OK;
                                    r_state <= S_SRD;
                                end
                            end
                            MODE_RETIRE: begin
                                r_stat    <= ST_OK;
                                r_retired <= 1'b1;
                                r_state   <= S_DONE;
                            end
                            default: begin
                                r_stat  <= ST_OK;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    if (r_first >= r_last || r_first >= PW'(NUM_PAGES)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_mode == MODE_RELEASE && ((~rdata & wmask) != 0)) begin
                        r_stat <= ST_DOUBLE;
                    end
                    if ((PW'(r_waddr) + PW'(1)) << BIT_W >= r_last ||
                        r_waddr == WA_W'(NWORDS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_waddr <= r_waddr + WA_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_SRD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (cur_page >= PW'(NUM_PAGES)) begin
                        r_stat  <= ST_NOFREE;
                        r_state <= S_DONE;
                    end else if (page_bit) begin
                        r_cand <= cand_rnd;
                    end else if (cur_page >= r_cand && run_len >= r_area) begin
                        r_start <= r_cand;
                        r_state <= S_SETUP;
                    end
                    if (cur_page < PW'(NUM_PAGES) &&
                        (page_bit || !(cur_page >= r_cand && run_len >= r_area))) begin
                        if (r_bit == (BIT_W+1)'(WORD_BITS - 1)) begin
                            r_bit   <= '0;
                            r_waddr <= r_waddr + WA_W'(1);
                            if (r_waddr == WA_W'(NWORDS - 1)) begin
                                r_stat  <= ST_NOFREE;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SRD;
                            end
                        end else begin
                            r_bit <= r_bit + (BIT_W+1)'(1);
                        end
                    end
                end
                S_SETUP: begin
                    r_lowest <= ADDR_W'(r_start << OFF_W);
                    if (atail) begin
                        if (PW'(r_size) < aroom) begin
                            r_last <= r_start;
                            r_toff <= OFF_W'(aoff + PW'(r_size));
                        end else begin
                            r_last  <= r_start + ((arest + PW'(PAGE_BYTES - 1)) >> OFF_W);
                            r_tpage <= r_start + ((arest + PW'(PAGE_BYTES - 1)) >> OFF_W)
                                       - PW'(1);
                            r_toff  <= OFF_W'(arest);
                        end
                    end else begin
                        r_last  <= r_start + r_area;
                        r_tpage <= r_start + r_area - PW'(1);
                        r_toff  <= OFF_W'(r_size);
                    end
                    if (ADDR_W'(aaddr) < r_alow) begin
                        r_alow <= ADDR_W'(aaddr);
                    end
                    if (SIZE_W'(aend) > r_ahigh) begin
                        r_ahigh <= SIZE_W'(aend);
                    end
                    r_res   <= ADDR_W'(aaddr);
                    r_first <= r_start;
                    r_waddr <= WA_W'(r_start >> BIT_W);
                    r_state <= S_RD;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("busy with done");
    a_retired_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(r_retired) && r_retired && r_mode != MODE_RETIRE)
        |-> o_status == ST_RETIRED) else $error("retired not reported");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !we) else $error("write while idle");
`endif
endmodule

// ===== tb/tb_bitmap_page_allocator.sv =====
// testbench for bitmap_page_allocator: directed and random requests with a bitmap predictor
// depends on bpa_pkg and the allocator rtl
`timescale 1ns / 1ps
module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    localparam longint unsigned PG    = PAGE_BYTES_DEF;
    localparam longint unsigned NPG   = NUM_PAGES_DEF;
    localparam longint unsigned AMASK = 64'hFF_FFFF;
    localparam longint unsigned HMAX  = 64'h1FF_FFFF;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] cnt;
        logic [ALOG_W-1:0] alog;
    } req_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] low;
        logic [SIZE_W-1:0] high;
    } rsp_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic [MODE_W-1:0] i_mode;
    logic [ADDR_W-1:0] i_byte_address;
    logic [SIZE_W-1:0] i_byte_count;
    logic [ALOG_W-1:0] i_align_log2;
    logic              o_done;
    logic [ADDR_W-1:0] o_result_address;
    logic [STAT_W-1:0] o_status;
    logic [ADDR_W-1:0] o_range_low;
    logic [SIZE_W-1:0] o_range_high;

    bitmap_page_allocator u_dut (.*);

    req_t pending_q[$];
    rsp_t expected_q[$];
    int   errors = 0;
    int   sent = 0;
    bit   stim_done = 0;

    bit              used_map[NPG];
    longint unsigned tail_page, tail_off, lowest_ok, range_lo, range_hi;
    bit              is_retired;

    function automatic longint unsigned rnd_up(longint unsigned x, longint unsigned a);
        return ((x + a - 1) / a) * a;
    endfunction

    function automatic void set_pages(longint unsigned first, longint unsigned n, bit v);
        for (longint unsigned p = first; p < first + n && p < NPG; p++) used_map[p] = v;
    endfunction

    function automatic rsp_t predict_allocator(req_t r);
        rsp_t            o;
        longint unsigned a, sz, al, area, incr, cand, strt, ad, fin, off, room, rest;
        longint unsigned last, p;
        bit              found;
        a = r.addr;
        sz = r.cnt;
        o.addr = '0;
        o.status = ST_OK;
        if (is_retired) begin
            o.status = ST_RETIRED;
        end else if (r.mode == MODE_RESERVE) begin
            set_pages(a / PG, (sz + (a % PG) + PG - 1) / PG, 1);
        end else if (r.mode == MODE_FREE) begin
            set_pages(a / PG, (sz + PG - 1) / PG, 0);
        end else if (r.mode == MODE_ALLOC) begin
            al = 64'd1 << r.alog;
            area = (sz + PG - 1) / PG;
            incr = al / PG;
            if (incr == 0) incr = 1;
            cand = 0;
            strt = 0;
            found = 0;
            if (sz != 0) begin
                for (p = 0; p < NPG; p++) begin
                    if (used_map[p]) cand = rnd_up(p + 1, incr);
                    else if (p >= cand && p - cand + 1 >= area) begin
                        strt = cand;
                        found = 1;
                        break;
                    end
                end
            end
            if (!found) begin
                o.status = ST_NOFREE;
            end else begin
                lowest_ok = (strt * PG) & AMASK;
                if (al < PG && tail_off != 0 && tail_page + 1 == strt) begin
                    off = rnd_up(tail_off, al);
                    room = PG - off;
                    ad = tail_page * PG + off;
                    if (sz < room) begin
                        area = 0;
                        tail_off = off + sz;
                    end else begin
                        rest = sz - room;
                        area = (rest + PG - 1) / PG;
                        tail_page = strt + area - 1;
                        tail_off = rest;
                    end
                    tail_off &= PG - 1;
                end else begin
                    tail_page = strt + area - 1;
                    tail_off = sz & (PG - 1);
                    ad = strt * PG;
                end
                set_pages(strt, area, 1);
                ad &= AMASK;
                fin = rnd_up(ad + sz, al);
                if (fin > HMAX) fin = HMAX;
                if (ad < range_lo) range_lo = ad;
                if (fin > range_hi) range_hi = fin;
                o.addr = ADDR_W'(ad);
            end
        end else if (r.mode == MODE_RELEASE) begin
            last = (a + sz) / PG;
            if (a < lowest_ok) lowest_ok = a;
            for (p = (a + PG - 1) / PG; p < last && p < NPG; p++) begin
                if (!used_map[p]) o.status = ST_DOUBLE;
                used_map[p] = 0;
            end
        end else if (r.mode == MODE_RETIRE) begin
            is_retired = 1;
        end
        o.low = ADDR_W'(range_lo);
        o.high = SIZE_W'(range_hi);
        return o;
    endfunction

    initial i_clk = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    initial begin
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
    end

    initial begin
        i_start = 0;
        i_mode = '0;
        i_byte_address = '0;
        i_byte_count = '0;
        i_align_log2 = '0;
        for (int p = 0; p < NPG; p++) used_map[p] = 1;
        tail_page = 0;
        tail_off = 0;
        lowest_ok = 0;
        range_lo = AMASK;
        range_hi = 0;
        is_retired = 0;
    end

    // driver
    always @(posedge i_clk) begin
        int pct;
        if (!i_rst_n) begin
            i_start <= 0;
        end else begin
            if (i_start && !o_busy) begin
                expected_q.push_back(predict_allocator(pending_q.pop_front()));
                sent++;
            end
            if (i_start && o_busy) begin
                i_start <= 1;
            end else begin
                pct = sent < 150 ? 25 : (sent < 300 ? 72 : 0);
                if (pending_q.size() == 0 || $urandom_range(99) < pct ||
                    (sent == 220 && (expected_q.size() != 0 || (i_start && !o_busy)))) begin
                    i_start <= 0;
                end else begin
                    i_start <= 1;
                    i_mode <= pending_q[0].mode;
                    i_byte_address <= pending_q[0].addr;
                    i_byte_count <= pending_q[0].cnt;
                    i_align_log2 <= pending_q[0].alog;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        rsp_t e;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_result_address !== e.addr) begin
                    $error("result_address exp %h got %h", e.addr, o_result_address);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %h got %h", e.status, o_status);
                    errors++;
                end
                if (o_range_low !== e.low) begin
                    $error("range_low exp %h got %h", e.low, o_range_low);
                    errors++;
                end
                if (o_range_high !== e.high) begin
                    $error("range_high exp %h got %h", e.high, o_range_high);
                    errors++;
                end
            end
        end
    end

    function automatic void add(logic [MODE_W-1:0] m, longint unsigned a, longint unsigned c,
                                int al);
        req_t r;
        r.mode = m;
        r.addr = ADDR_W'(a);
        r.cnt = SIZE_W'(c);
        r.alog = ALOG_W'(al);
        pending_q.push_back(r);
    endfunction

    function automatic longint unsigned rand_size();
        int k;
        k = $urandom_range(99);
        if (k < 60) return $urandom_range(4000, 1);
        if (k < 90) return $urandom_range(60000, 1);
        if (k < 97) return $urandom_range(2000000, 1);
        return $urandom_range(16777216, 1);
    endfunction

    initial begin
        longint unsigned a, c;
        int k;
        add(MODE_FREE, 0, 16777216, 0);
        add(MODE_ALLOC, 0, 1, 0);
        add(MODE_ALLOC, 0, 100, 3);
        add(MODE_ALLOC, 0, 4000, 2);
        add(MODE_ALLOC, 0, 0, 0);
        add(MODE_ALLOC, 0, 16777216, 23);
        add(MODE_ALLOC, 0, 4096, 12);
        add(MODE_ALLOC, 0, 70000, 16);
        add(MODE_ALLOC, 0, 5000, 31);
        add(MODE_RELEASE, 0, 16384, 0);
        add(MODE_RELEASE, 0, 16384, 0);
        add(MODE_RESERVE, 24'hABC123, 9000, 0);
        add(MODE_RESERVE, 24'hFFFFFF, 16777216, 0);
        add(MODE_RELEASE, 24'hFFFFFF, 16777216, 0);
        add(3'd5, 24'h555555, 25'h0AAAAAA, 5'd21);
        add(3'd6, 0, 1, 0);
        add(3'd7, 24'hFFFFFF, 25'h1000000, 5'd23);
        add(MODE_FREE, 0, 16777216, 0);
        add(MODE_ALLOC, 0, 16777216, 0);
        add(MODE_FREE, 0, 16777216, 0);
        add(MODE_ALLOC, 0, 1, 23);
        for (int i = 0; i < 450; i++) begin
            k = $urandom_range(99);
            a = $urandom_range(24'hFFFFFF, 0);
            c = rand_size();
            if (k < 50) add(MODE_ALLOC, 0, c, $urandom_range(k < 40 ? 14 : 23, 0));
            else if (k < 75) add(MODE_RELEASE, a & ~(longint'(PG) - 1), c, 0);
            else if (k < 82) add(MODE_RELEASE, a, c, 0);
            else if (k < 90) add(MODE_FREE, a, c, 0);
            else if (k < 95) add(MODE_RESERVE, a, c, 0);
            else if (k < 98) add(MODE_FREE, 0, 16777216, 0);
            else add(MODE_ALLOC, 0, c, 0);
        end
        add(MODE_RETIRE, 0, 1, 0);
        add(MODE_ALLOC, 0, 1, 0);
        add(MODE_RETIRE, 0, 1, 0);
        add(MODE_FREE, 0, 4096, 0);
        wait (pending_q.size() == 0);
        @(posedge i_clk);
        wait (!i_start && expected_q.size() == 0);
        repeat (600) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) $display("tb_bitmap_page_allocator: clean");
        else $display("tb_bitmap_page_allocator: errors");
        $finish;
    end

    initial begin
        #100ms;
        $display("tb_bitmap_page_allocator: errors");
        $finish;
    end
endmodule
